/* src/position_frame_packer_unit_macros.svh */
// ---------------------------------------------------------------------------
// position_frame_packer_unit_macros.svh
// assertion macros used by the frame packer emit stage
// ---------------------------------------------------------------------------
`ifndef POSITION_FRAME_PACKER_UNIT_MACROS_SVH
`define POSITION_FRAME_PACKER_UNIT_MACROS_SVH

// check on every edge outside reset
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define PFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pfp_pkg.sv */
// ---------------------------------------------------------------------------
// pfp_pkg
// shared constants and types of the position frame packer
// ---------------------------------------------------------------------------
package pfp_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned DATA_LEN  = 18;
  localparam int unsigned IDX_W     = 5;

  localparam logic [IDX_W-1:0] SUM_IDX  = IDX_W'(DATA_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  // header bytes
  localparam logic [7:0] HDR_0 = 8'hEE;
  localparam logic [7:0] HDR_1 = 8'h90;
  localparam logic [7:0] HDR_2 = 8'h51;

  // coordinate codes must lie strictly between zero and this bound
  localparam logic [31:0] COORD_LIMIT = 32'd1800000000;

  // control from the emit stage back to the cell chain and input side
  typedef struct packed {
    logic shift;  // chain moves one byte toward the head
    logic free;   // a new sample may be taken this cycle
  } pfp_ctl_t;

endpackage

/* src/pfp_cell.sv */
// ---------------------------------------------------------------------------
// pfp_cell
// one byte cell of the frame chain: parallel load or shift from neighbor
// ---------------------------------------------------------------------------
module pfp_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] from_next,
  output logic [7:0] byte_q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // load wins over shift
  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = load_byte;
    end else if (shift) begin
      byte_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

/* src/pfp_emit.sv */
// ---------------------------------------------------------------------------
// pfp_emit
// head of the chain: byte counter, running checksums and output register
// ---------------------------------------------------------------------------
`include "position_frame_packer_unit_macros.svh"

module pfp_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [7:0]           head_byte,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output pfp_pkg::pfp_ctl_t    ctl
);

  logic                      busy_r, busy_nxt;
  logic [pfp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [7:0]                obyte_r, obyte_nxt;
  logic                      olast_r, olast_nxt;
  logic                      adv;
  logic                      is_data;
  logic                      is_last;
  logic [7:0]                sel_byte;

  // while a frame is in flight, one byte moves into the output register when it is empty or draining
  assign adv     = busy_r && (!ovalid_r || out_tready);
  assign is_data = idx_r < pfp_pkg::SUM_IDX;
  assign is_last = idx_r == pfp_pkg::LAST_IDX;

  assign ctl.shift = adv;
  assign ctl.free  = !busy_r || (adv && is_last);

  // byte for the current slot
  always_comb begin
    if (is_data) begin
      sel_byte = head_byte;
    end else if (idx_r == pfp_pkg::SUM_IDX) begin
      sel_byte = sum_r;
    end else begin
      sel_byte = xor_r;
    end
  end

  // counter and checksums
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    xor_nxt  = xor_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      sum_nxt  = '0;
      xor_nxt  = '0;
    end else if (adv) begin
      if (is_last) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
      if (is_data) begin
        sum_nxt = sum_r + head_byte;
        xor_nxt = xor_r ^ head_byte;
      end else if (idx_r == pfp_pkg::SUM_IDX) begin
        xor_nxt = xor_r ^ sum_r;
      end
    end
  end

  // output register
  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    if (adv) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = sel_byte;
      olast_nxt  = is_last;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    xor_r   <= xor_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;

  // checks
  `PFP_ASSERT(a_load_when_free, load |-> ctl.free, "sample loaded while frame in flight")
  `PFP_ASSERT(a_idx_range, idx_r <= pfp_pkg::LAST_IDX, "byte counter past frame end")
  `PFP_ASSERT(a_idle_idx, !busy_r |-> idx_r == '0, "byte counter not cleared when idle")
  `PFP_ASSERT(a_frame_end, (adv && is_last && !load) |=> !busy_r, "frame did not end")
  `PFP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy_r && !ovalid_r), "reset left block busy")

endmodule

/* src/position_frame_packer_unit.sv */
// ---------------------------------------------------------------------------
// position_frame_packer_unit
// packs one position sample into a 20-byte link frame, sent a byte at a time
// ---------------------------------------------------------------------------
// channel  | dir | handshake         | payload
// in_      | in  | in_tvalid/tready  | in_tdata: 120-bit position sample
// out_     | out | out_tvalid/tready | out_tdata: frame byte, out_tlast: end
//
// a frame is 20 bytes, one byte per cycle while out_tready allows, from an 18-cell shift
// chain followed by the two checksum bytes; the next sample is taken in the
// cycle the last byte enters the output register, so frames run gap-free.
// a sample whose coordinates are out of range is taken but
// produces no output. reset clears control only; frame bytes need none.
// out_tready low with a byte waiting holds the output register and freezes
// the chain.
// ---------------------------------------------------------------------------
module position_frame_packer_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // lng_code[31:0], lat_code[63:32], alt_code[79:64], valid_byte[87:80],
  // range_code[103:88], yaw_code[119:104]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // frame_byte[7:0]
  output logic [7:0]   out_tdata,
  output logic         out_tlast
);

  logic signed [31:0] lng_code;
  logic signed [31:0] lat_code;
  logic signed [15:0] alt_code;
  logic        [7:0]  valid_byte;
  logic signed [15:0] range_code;
  logic signed [15:0] yaw_code;
  logic               coord_ok;
  logic               load;
  pfp_pkg::pfp_ctl_t  ctl;
  logic [7:0]         load_bytes [pfp_pkg::DATA_LEN];
  logic [7:0]         cell_q     [pfp_pkg::DATA_LEN];

  // unpack sample fields
  assign lng_code   = in_tdata[31:0];
  assign lat_code   = in_tdata[63:32];
  assign alt_code   = in_tdata[79:64];
  assign valid_byte = in_tdata[87:80];
  assign range_code = in_tdata[103:88];
  assign yaw_code   = in_tdata[119:104];

  // both coordinates strictly inside (0, limit); negatives read as huge
  assign coord_ok = (lng_code != '0) && (unsigned'(lng_code) < pfp_pkg::COORD_LIMIT) &&
                    (lat_code != '0) && (unsigned'(lat_code) < pfp_pkg::COORD_LIMIT);

  assign in_tready = ctl.free;
  assign load      = in_tvalid && in_tready && coord_ok;

  // frame bytes 0 to 17, big-endian words
  always_comb begin
    load_bytes[0]  = pfp_pkg::HDR_0;
    load_bytes[1]  = pfp_pkg::HDR_1;
    load_bytes[2]  = pfp_pkg::HDR_2;
    load_bytes[3]  = lng_code[31:24];
    load_bytes[4]  = lng_code[23:16];
    load_bytes[5]  = lng_code[15:8];
    load_bytes[6]  = lng_code[7:0];
    load_bytes[7]  = lat_code[31:24];
    load_bytes[8]  = lat_code[23:16];
    load_bytes[9]  = lat_code[15:8];
    load_bytes[10] = lat_code[7:0];
    load_bytes[11] = alt_code[15:8];
    load_bytes[12] = alt_code[7:0];
    load_bytes[13] = valid_byte;
    load_bytes[14] = range_code[15:8];
    load_bytes[15] = range_code[7:0];
    load_bytes[16] = yaw_code[15:8];
    load_bytes[17] = yaw_code[7:0];
  end

  // byte chain, cell 0 at the head
  for (genvar i = 0; i < pfp_pkg::DATA_LEN; i++) begin : g_cell
    if (i == pfp_pkg::DATA_LEN - 1) begin : g_tail
      pfp_cell u_cell (
        .clk       (clk),
        .load      (load),
        .shift     (ctl.shift),
        .load_byte (load_bytes[i]),
        .from_next (8'h00),
        .byte_q    (cell_q[i])
      );
    end else begin : g_mid
      pfp_cell u_cell (
        .clk       (clk),
        .load      (load),
        .shift     (ctl.shift),
        .load_byte (load_bytes[i]),
        .from_next (cell_q[i+1]),
        .byte_q    (cell_q[i])
      );
    end
  end

  // checksum and output stage
  pfp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .head_byte  (cell_q[0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .ctl        (ctl)
  );

endmodule
